// ===== design/binary_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the binary to decimal ASCII converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BDA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bda_pkg.sv =====
// Package with constants and types for the binary to decimal ASCII converter.
package bda_pkg;

   localparam int VALUE_W     = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int DIGIT_W     = 4;
   localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
   localparam int DIGIT_IDX_W = 4;
   localparam int STEP_W      = 5;
   localparam int CHAR_W      = 8;

   localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   localparam logic OPCODE_UNSIGNED = 1'b0;
   localparam logic OPCODE_SIGNED   = 1'b1;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NUM_DIGITS-1:0] bcd_type;

   typedef struct packed {
      logic                   done;
      logic [DIGIT_IDX_W-1:0] msd_idx;
   } dabble_status_type;

endpackage

// ===== design/bda_dabble.sv =====
// Bit-serial double dabble unit: 32-bit binary to ten BCD digits.
`include "binary_to_decimal_ascii_defines.svh"

module bda_dabble import bda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] mag,
   output bcd_type            digits,
   output dabble_status_type  status
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   bcd_type            bcd_ff, bcd_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   bcd_type            adj;
   logic [DIGIT_IDX_W-1:0] msd;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         adj[d] = (bcd_ff[d] >= 4'd5) ? bcd_ff[d] + 4'd3 : bcd_ff[d];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[NUM_DIGITS-1:0], bin_ff} << 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      msd = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d] != '0) begin
            msd = DIGIT_IDX_W'(d);
         end
      end
   end

   assign digits         = bcd_ff;
   assign status.done    = done_ff;
   assign status.msd_idx = msd;

   `BDA_ASSERT_SAME(a_start_idle, start, !busy_ff, "start while busy")
   `BDA_ASSERT_SAME(a_done_after_last, done_ff, $past(busy_ff) && $past(cnt_ff) == STEP_LAST,
      "done without final step")
   `BDA_ASSERT_SAME(a_done_not_busy, done_ff, !busy_ff, "done while busy")

endmodule

// ===== design/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Usage:
//   The req channel takes one 32-bit word per transfer; req_tuser selects
//   unsigned (0) or two's complement signed (1) reading of req_tdata.
//   The rsp channel returns the decimal text, most significant digit first,
//   one ASCII character per transfer in rsp_tdata, without leading zeros.
//   A negative signed word starts with '-'; zero gives a single '0'.
//   rsp_tlast marks the final character of each number.
// Timing:
//   After a transfer on req the double dabble unit runs one bit per cycle;
//   when it is done the characters follow one per cycle while rsp_tready is
//   high. A number gives 1 to 11 characters; req_tready is high only between
//   numbers, and stays high while the final character waits on rsp.
// Reset clears the sequencer state and rsp_tvalid; no number is pending.
// When the receiver stalls, the held character stays on rsp and the
// sequencer waits, with no loss.
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii import bda_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic              req_tuser,   // [0] opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata,   // [7:0] char_code
   output logic              rsp_tlast    // last_char
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   vld_ff, vld_in;
   logic [CHAR_W-1:0]      chr_ff, chr_in;
   logic                   last_ff, last_in;

   logic                   accept;
   logic                   out_free;
   logic                   neg_word;
   logic [VALUE_W-1:0]     mag;
   bcd_type                digits;
   dabble_status_type      dstat;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !vld_ff || rsp_tready;
   assign neg_word   = (req_tuser == OPCODE_SIGNED) && req_tdata[VALUE_W-1];
   assign mag        = neg_word ? (~req_tdata + 32'd1) : req_tdata;

   bda_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mag    (mag),
      .digits (digits),
      .status (dstat)
   );

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      idx_in   = idx_ff;
      vld_in   = vld_ff && !rsp_tready;
      chr_in   = chr_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = neg_word;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (dstat.done) begin
               idx_in   = dstat.msd_idx;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               vld_in   = 1'b1;
               chr_in   = ASCII_MINUS;
               last_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               vld_in  = 1'b1;
               chr_in  = ASCII_ZERO | {4'd0, digits[idx_ff]};
               last_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 4'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      chr_ff  <= chr_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = chr_ff;
   assign rsp_tlast  = last_ff;

   `BDA_ASSERT_NEXT(a_accept_conv, accept, state_ff == ST_CONV, "accept did not start conversion")
   `BDA_ASSERT_SAME(a_done_in_conv, dstat.done, state_ff == ST_CONV, "conversion done out of turn")
   `BDA_ASSERT_SAME(a_emit_idx, state_ff == ST_EMIT, idx_ff < DIGIT_IDX_W'(NUM_DIGITS),
      "digit index out of range")
   `BDA_ASSERT_SAME(a_sign_neg, state_ff == ST_SIGN, neg_ff, "minus sign for non-negative word")

endmodule

// ===== dv/binary_to_decimal_ascii_test.sv =====
// Testbench for the binary to decimal ASCII converter: streams numbers in and checks every character.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test import bda_pkg::*; ();

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 13;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_NUMBERS = 137;

   class decimal_text_board;
      logic [CHAR_W-1:0] char_q[$];
      logic              last_q[$];
      int unsigned       mismatches;
      int unsigned       numbers_seen;
      int unsigned       negatives_seen;
      int unsigned       chars_checked;
      int unsigned       longest_text;

      function void note_number(logic opcode, logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] magnitude;
         logic [DIGIT_W-1:0] digits[$];
         int unsigned        text_len;
         magnitude = value;
         text_len = 0;
         numbers_seen++;
         if (opcode == OPCODE_SIGNED && value[VALUE_W-1]) begin
            magnitude = ~value + 1'b1;
            char_q.push_back(ASCII_MINUS);
            last_q.push_back(1'b0);
            negatives_seen++;
            text_len++;
         end
         do begin
            digits.push_front(DIGIT_W'(magnitude % 10));
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         foreach (digits[i]) begin
            char_q.push_back(ASCII_ZERO + CHAR_W'(digits[i]));
            last_q.push_back(i == digits.size() - 1);
         end
         text_len += digits.size();
         if (text_len > longest_text) longest_text = text_len;
      endfunction

      function void check_char(logic [CHAR_W-1:0] char_code, logic last_char);
         logic [CHAR_W-1:0] want_code;
         logic              want_last;
         if (char_q.size() == 0) begin
            $error("char_code: no character pending, got %h (last_char %b)",
                   char_code, last_char);
            mismatches++;
            return;
         end
         want_code = char_q.pop_front();
         want_last = last_q.pop_front();
         chars_checked++;
         if (char_code !== want_code) begin
            $error("char_code: expected %h, got %h", want_code, char_code);
            mismatches++;
         end
         if (last_char !== want_last) begin
            $error("last_char: expected %b, got %b", want_last, last_char);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return char_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // [31:0] value
   logic              req_tuser = 1'b0; // [0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [CHAR_W-1:0] rsp_tdata;        // [7:0] char_code
   logic              rsp_tlast;

   decimal_text_board board = new();
   bit                quiet_stretch = 1'b0;
   bit                hold_request = 1'b0;
   int unsigned       idle_cycles = 0;
   int unsigned       long_holds = 0;

   binary_to_decimal_ascii u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_number(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_char(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // hold the number until it is taken; keep tvalid high across back-to-back transfers
   task automatic send_number(logic opcode, logic [VALUE_W-1:0] value);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= opcode;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 1'b0;
            long_holds++;
         end else if (quiet_stretch) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic               op_list[$];
      logic [VALUE_W-1:0] value_list[$];
      logic               opcode;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] decade;
      int                 k;

      op_list = '{OPCODE_UNSIGNED, OPCODE_SIGNED, OPCODE_UNSIGNED, OPCODE_UNSIGNED,
                  OPCODE_UNSIGNED, OPCODE_UNSIGNED, OPCODE_UNSIGNED, OPCODE_UNSIGNED,
                  OPCODE_UNSIGNED, OPCODE_UNSIGNED, OPCODE_SIGNED, OPCODE_SIGNED,
                  OPCODE_UNSIGNED, OPCODE_SIGNED, OPCODE_UNSIGNED, OPCODE_SIGNED,
                  OPCODE_SIGNED, OPCODE_SIGNED, OPCODE_UNSIGNED, OPCODE_UNSIGNED,
                  OPCODE_SIGNED, OPCODE_SIGNED, OPCODE_UNSIGNED};
      value_list = '{32'd0, 32'd0, 32'd1, 32'd9,
                     32'd10, 32'd99, 32'd100, 32'd999999999,
                     32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd12345,
                     32'hFFFF_FFF6, 32'hC465_3600, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'hAAAA_AAAA, 32'h3B9A_CA00, 32'hFFFF_FFFE};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (op_list[i]) send_number(op_list[i], value_list[i]);

      // stall the receiver for a long stretch while numbers keep coming
      hold_request = 1'b1;
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         if (n % 25 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
         opcode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 7))
            0, 1: value = $urandom;
            2: begin
               k = $urandom_range(0, 9);
               decade = 1;
               repeat (k) decade = decade * 10;
               value = decade + $urandom_range(0, 2) - 1;
            end
            3: begin
               opcode = OPCODE_SIGNED;
               value = ~VALUE_W'($urandom_range(0, 999));
            end
            default: value = $urandom >> $urandom_range(0, VALUE_W - 1);
         endcase
         send_number(opcode, value);
      end
      req_tvalid <= 1'b0;
      quiet_stretch = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d negative), checked %0d characters, longest text %0d",
               board.numbers_seen, board.negatives_seen, board.chars_checked,
               board.longest_text);
      $display("Receiver held off %0d long stretch(es) of %0d cycles with input pending",
               long_holds, LONG_HOLD);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
